@@ rtl/length_prefix_chunk_framer_assert.svh @@
// Assertion macros for the length-prefix chunk framer
`ifndef LENGTH_PREFIX_CHUNK_FRAMER_ASSERT_SVH
`define LENGTH_PREFIX_CHUNK_FRAMER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LPCF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("lpcf assertion failed");
// next-cycle implication
`define LPCF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("lpcf assertion failed");
`else
`define LPCF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define LPCF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/lpcf_pkg.sv @@
// Shared types and constants for the length-prefix chunk framer
`default_nettype none
package lpcf_pkg;

    localparam int LPCF_FIFO_DEPTH = 4;
    localparam int LPCF_CFG_IDX_W  = 1;
    localparam int LPCF_CFG_DATA_W = 16;

    localparam logic [15:0] LPCF_MAX_CHUNK_RESET = 16'd65507;

    localparam logic [LPCF_CFG_IDX_W-1:0] CFG_SPLIT_MODE = 1'b0;
    localparam logic [LPCF_CFG_IDX_W-1:0] CFG_MAX_CHUNK  = 1'b1;

    // one classified payload byte, queued from front to back
    typedef struct packed {
        logic [7:0]  data;
        logic        hdr;
        logic [15:0] chunk_len;
        logic        last;
    } t_cmd;

    typedef enum logic [1:0] {
        PH_HI,
        PH_LO,
        PH_DATA
    } t_phase;

endpackage
`default_nettype wire

@@ rtl/length_prefix_chunk_framer.sv @@
// Top level of the length-prefix chunk framer
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one payload byte per request;
//   the first byte of a packet carries i_first_byte and the packet length.
//   Output channel (o_out_valid / i_out_stall) gives one framed byte per request:
//   a two-byte big-endian chunk length (o_is_header) before each chunk, then the
//   chunk's bytes, o_packet_end on the last byte of the packet. Oversized packets
//   are chunked when split mode is set, otherwise silently dropped.
//   Config channel (i_cfg_valid / o_cfg_ready) is always ready; write only when idle.
// Timing:
//   A byte goes through the command queue and the output register before it is
//   presented; a byte opening a chunk follows its two header bytes. Output moves
//   one byte per cycle unless stalled; input takes one byte per cycle except that
//   each chunk header adds two output bytes, which the queue (DEPTH entries) absorbs
//   first. Dropped and ignored bytes are taken every cycle while the queue has room.
// Reset: synchronous, clears packet state and the queue, split mode off, max_chunk 65507.
// Stall: with i_out_stall high the output byte holds; the queue fills and then
//   o_in_stall is raised until room frees up.
`default_nettype none
`include "length_prefix_chunk_framer_assert.svh"
module length_prefix_chunk_framer
    import lpcf_pkg::*;
#(
    parameter int DEPTH = LPCF_FIFO_DEPTH
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire [LPCF_CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [LPCF_CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                        i_in_valid,
    output logic                       o_in_stall,
    input  wire [7:0]                  i_data_byte,
    input  wire                        i_first_byte,
    input  wire [23:0]                 i_pkt_len,
    output logic                       o_out_valid,
    input  wire                        i_out_stall,
    output logic [7:0]                 o_out_byte,
    output logic                       o_is_header,
    output logic                       o_packet_end
);

    logic w_accept;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_cmd w_cmd;
    t_cmd w_head;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_full;
    assign w_accept    = i_in_valid && !w_full;

    lpcf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (w_accept),
        .i_data_byte  (i_data_byte),
        .i_first_byte (i_first_byte),
        .i_pkt_len    (i_pkt_len),
        .o_push       (w_push),
        .o_cmd        (w_cmd)
    );

    lpcf_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_din   (w_cmd),
        .i_pop   (w_pop),
        .o_dout  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    lpcf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_is_header  (o_is_header),
        .o_packet_end (o_packet_end)
    );

    // queue never written when full nor read when empty
    `LPCF_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, w_push, !w_full)
    `LPCF_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, w_pop, !w_empty)
    // length prefix bytes never close a packet
    `LPCF_ASSERT_IMPL(a_hdr_not_end, i_clk, i_rst_n, o_out_valid && o_is_header, !o_packet_end)
    // a header byte taken is always followed by another output byte
    `LPCF_ASSERT_NEXT(a_hdr_follow, i_clk, i_rst_n, o_out_valid && o_is_header && !i_out_stall, o_out_valid)

endmodule
`default_nettype wire

@@ rtl/lpcf_fifo.sv @@
// Small command queue between the front and back parts of the framer
`default_nettype none
module lpcf_fifo
    import lpcf_pkg::*;
#(
    parameter int DEPTH = LPCF_FIFO_DEPTH
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_push,
    input  wire t_cmd i_din,
    input  wire       i_pop,
    output t_cmd      o_dout,
    output logic      o_full,
    output logic      o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_din;
        end
    end

    assign o_dout  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);

endmodule
`default_nettype wire

@@ rtl/lpcf_front.sv @@
// Front part: config registers, packet tracking and byte classification
`default_nettype none
module lpcf_front
    import lpcf_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_valid,
    input  wire [LPCF_CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [LPCF_CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                        i_accept,
    input  wire [7:0]                  i_data_byte,
    input  wire                        i_first_byte,
    input  wire [23:0]                 i_pkt_len,
    output logic                       o_push,
    output t_cmd                       o_cmd
);

    logic        r_split_mode;
    logic [15:0] r_max_chunk;
    logic [23:0] r_packet_left, n_packet_left;
    logic [15:0] r_chunk_left,  n_chunk_left;
    logic        r_dropping,    n_dropping;

    logic [15:0] w_eff_max;

    assign w_eff_max = (r_max_chunk == '0) ? 16'd1 : r_max_chunk;

    always_comb begin
        logic [23:0] pl;
        logic [15:0] cl;
        logic        dr;
        logic        active;
        logic        hdr;
        logic [15:0] c;
        logic [23:0] pl_dec;

        pl     = r_packet_left;
        cl     = r_chunk_left;
        dr     = r_dropping;
        active = i_accept;
        hdr    = 1'b0;
        c      = '0;
        pl_dec = '0;

        n_packet_left = r_packet_left;
        n_chunk_left  = r_chunk_left;
        n_dropping    = r_dropping;
        o_push        = 1'b0;
        o_cmd         = '0;

        if (i_accept) begin
            if (i_first_byte) begin
                pl = i_pkt_len;
                cl = '0;
                dr = (i_pkt_len > {8'd0, w_eff_max}) && !r_split_mode;
                if (i_pkt_len == '0) begin
                    // zero length: abandon whatever was open, start nothing
                    active        = 1'b0;
                    n_packet_left = '0;
                    n_chunk_left  = '0;
                    n_dropping    = 1'b0;
                end
            end else if (r_packet_left == '0) begin
                active = 1'b0;
            end
        end

        if (active) begin
            pl_dec = pl - 24'd1;
            if (dr) begin
                n_packet_left = pl_dec;
                n_chunk_left  = cl;
                n_dropping    = (pl_dec != '0);
            end else begin
                hdr = (cl == '0);
                c   = (pl < {8'd0, w_eff_max}) ? pl[15:0] : w_eff_max;
                n_chunk_left  = (hdr ? c : cl) - 16'd1;
                n_packet_left = pl_dec;
                n_dropping    = 1'b0;
                o_push          = 1'b1;
                o_cmd.data      = i_data_byte;
                o_cmd.hdr       = hdr;
                o_cmd.chunk_len = c;
                o_cmd.last      = (pl_dec == '0);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split_mode  <= 1'b0;
            r_max_chunk   <= LPCF_MAX_CHUNK_RESET;
            r_packet_left <= '0;
            r_chunk_left  <= '0;
            r_dropping    <= 1'b0;
        end else begin
            r_packet_left <= n_packet_left;
            r_chunk_left  <= n_chunk_left;
            r_dropping    <= n_dropping;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SPLIT_MODE: begin
                        r_split_mode <= i_cfg_data[0];
                    end
                    CFG_MAX_CHUNK: begin
                        r_max_chunk <= i_cfg_data[15:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule
`default_nettype wire

@@ rtl/lpcf_back.sv @@
// Back part: expands queued commands into header and payload bytes
`default_nettype none
module lpcf_back
    import lpcf_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire t_cmd  i_head,
    input  wire        i_empty,
    output logic       o_pop,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_is_header,
    output logic       o_packet_end
);

    t_phase      r_phase, n_phase;
    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte,  n_out_byte;
    logic        r_is_header, n_is_header;
    logic        r_packet_end, n_packet_end;
    logic        w_load;

    // output register may be refilled when empty or being taken
    assign w_load = !i_empty && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_phase = r_phase;
        if (w_load) begin
            case (r_phase)
                PH_HI:   n_phase = i_head.hdr ? PH_LO : PH_HI;
                PH_LO:   n_phase = PH_DATA;
                PH_DATA: n_phase = PH_HI;
                default: n_phase = PH_HI;
            endcase
        end
    end

    always_comb begin
        o_pop        = 1'b0;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_byte   = r_out_byte;
        n_is_header  = r_is_header;
        n_packet_end = r_packet_end;
        if (w_load) begin
            n_out_valid = 1'b1;
            case (r_phase)
                PH_HI: begin
                    if (i_head.hdr) begin
                        n_out_byte   = i_head.chunk_len[15:8];
                        n_is_header  = 1'b1;
                        n_packet_end = 1'b0;
                    end else begin
                        n_out_byte   = i_head.data;
                        n_is_header  = 1'b0;
                        n_packet_end = i_head.last;
                        o_pop        = 1'b1;
                    end
                end
                PH_LO: begin
                    n_out_byte   = i_head.chunk_len[7:0];
                    n_is_header  = 1'b1;
                    n_packet_end = 1'b0;
                end
                default: begin
                    n_out_byte   = i_head.data;
                    n_is_header  = 1'b0;
                    n_packet_end = i_head.last;
                    o_pop        = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HI;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte   <= n_out_byte;
        r_is_header  <= n_is_header;
        r_packet_end <= n_packet_end;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_is_header  = r_is_header;
    assign o_packet_end = r_packet_end;

endmodule
`default_nettype wire
